// ===== rtl/core/svs_pkg.sv =====
// Shared constants, codes and types of the supply voltage supervisor.
package svs_pkg;

    localparam int HYSTERESIS_MV     = 50;
    localparam int COUNTDOWN_SECONDS = 172800;

    localparam int MV_W       = 21;
    localparam int REM_W      = 18;
    localparam int DISP_W     = 6;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [MV_W-1:0]  MV_MAX          = '1;
    localparam logic [21:0]      HYST_MV         = 22'(HYSTERESIS_MV);
    localparam logic [REM_W-1:0] COUNTDOWN_LOAD  = REM_W'(COUNTDOWN_SECONDS);
    localparam logic [29:0]      SAT_LIMIT       = 30'd209715200;
    localparam logic [26:0]      DIV100_RECIP    = 27'd85899346;
    localparam logic [14:0]      HOUR_RECIP      = 15'd18642;
    localparam logic [10:0]      MIN_RECIP       = 11'd1093;
    localparam logic [11:0]      SECS_PER_HOUR   = 12'd3600;
    localparam logic [5:0]       SECS_PER_MIN    = 6'd60;
    localparam logic [6:0]       HOURS_SHOWN_MAX = 7'd63;

    localparam logic [1:0] ST_NORMAL = 2'd0;
    localparam logic [1:0] ST_UNDER  = 2'd1;
    localparam logic [1:0] ST_LOW    = 2'd2;
    localparam logic [1:0] ST_CUT    = 2'd3;

    localparam logic [1:0] UV_NONE     = 2'd0;
    localparam logic [1:0] UV_COUNTING = 2'd1;
    localparam logic [1:0] UV_EXPIRED  = 2'd2;
    localparam logic [1:0] UV_LOW_CUT  = 2'd3;

    localparam logic [1:0] MARK_CLEAR       = 2'd0;
    localparam logic [1:0] MARK_FROM_NORMAL = 2'd1;
    localparam logic [1:0] MARK_FROM_LOW    = 2'd3;

    localparam logic [3:0] EV_NONE          = 4'd0;
    localparam logic [3:0] EV_NORMAL_CUT    = 4'd1;
    localparam logic [3:0] EV_NORMAL_LOW    = 4'd2;
    localparam logic [3:0] EV_NORMAL_UNDER  = 4'd3;
    localparam logic [3:0] EV_UNDER_NORMAL  = 4'd4;
    localparam logic [3:0] EV_UNDER_LOW     = 4'd5;
    localparam logic [3:0] EV_UNDER_CUT     = 4'd6;
    localparam logic [3:0] EV_LOW_NORMAL    = 4'd7;
    localparam logic [3:0] EV_LOW_UNDER     = 4'd8;
    localparam logic [3:0] EV_LOW_CUT       = 4'd9;
    localparam logic [3:0] EV_CUT_NORMAL    = 4'd10;
    localparam logic [3:0] EV_CUT_UNDER     = 4'd11;
    localparam logic [3:0] EV_CUT_LOW       = 4'd12;
    localparam logic [3:0] EV_STARTUP       = 4'd13;

    localparam logic REQ_SAMPLE = 1'b0;
    localparam logic REQ_TICK   = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_VOLT_UNDER = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_VOLT_LOW   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_VOLT_CUT   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_VOLT_START = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_REF_MV     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_DIV_GAIN   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_EIGHT_BIT  = 3'd6;

    localparam logic [15:0] RST_VOLT_UNDER = 16'd3300;
    localparam logic [15:0] RST_VOLT_LOW   = 16'd3000;
    localparam logic [15:0] RST_VOLT_CUT   = 16'd1000;
    localparam logic [15:0] RST_VOLT_START = 16'd3000;
    localparam logic [12:0] RST_REF_MV     = 13'd3300;
    localparam logic [14:0] RST_DIV_GAIN   = 15'd500;

    typedef struct packed {
        logic load;
        logic step1;
        logic step2;
        logic step3;
        logic step4;
        logic commit;
    } t_cmd;

    typedef struct packed {
        logic in_accept;
        logic out_free;
    } t_status;

    typedef struct packed {
        logic [1:0]        power_state;
        logic [MV_W-1:0]   measured_mv;
        logic [3:0]        transition_event;
        logic [1:0]        undervolt_flag;
        logic [1:0]        normal_to_under_mark;
        logic              valve_hold;
        logic              save_request;
        logic              reload_request;
        logic [DISP_W-1:0] hours_left;
        logic [DISP_W-1:0] minutes_left;
        logic [DISP_W-1:0] seconds_left;
    } t_result;

endpackage

// ===== rtl/core/svs_ctrl.sv =====
// Sequencer that steps one item through the datapath and commits its result.
module svs_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  svs_pkg::t_status i_status,
    output logic             o_idle,
    output svs_pkg::t_cmd    o_cmd
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_STEP1  = 3'd1;
    localparam logic [2:0] S_STEP2  = 3'd2;
    localparam logic [2:0] S_STEP3  = 3'd3;
    localparam logic [2:0] S_STEP4  = 3'd4;
    localparam logic [2:0] S_COMMIT = 3'd5;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_comb begin
        n_state      = r_state;
        o_cmd        = '0;
        o_cmd.load   = i_status.in_accept;
        unique case (r_state)
            S_IDLE: begin
                if (i_status.in_accept) begin
                    n_state = S_STEP1;
                end
            end
            S_STEP1: begin
                o_cmd.step1 = 1'b1;
                n_state     = S_STEP2;
            end
            S_STEP2: begin
                o_cmd.step2 = 1'b1;
                n_state     = S_STEP3;
            end
            S_STEP3: begin
                o_cmd.step3 = 1'b1;
                n_state     = S_STEP4;
            end
            S_STEP4: begin
                o_cmd.step4 = 1'b1;
                n_state     = S_COMMIT;
            end
            S_COMMIT: begin
                if (i_status.out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_idle = (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ===== rtl/core/svs_dpath.sv =====
// Scaling arithmetic, countdown display arithmetic and supervisor state update.
module svs_dpath (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  svs_pkg::t_cmd                    i_cmd,
    input  logic                             i_cfg_we,
    input  logic [svs_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [svs_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic                             i_req_type,
    input  logic [9:0]                       i_adc_code,
    input  logic                             i_comm_busy,
    output svs_pkg::t_result                 o_result
);

    logic [15:0] r_volt_under;
    logic [15:0] r_volt_low;
    logic [15:0] r_volt_cut;
    logic [15:0] r_volt_start;
    logic [12:0] r_ref_mv;
    logic [14:0] r_div_gain;
    logic        r_eight_bit;

    logic [1:0]                      r_supply_state;
    logic                            r_started;
    logic [1:0]                      r_uv_code;
    logic [1:0]                      r_mark;
    logic                            r_valve;
    logic [svs_pkg::REM_W-1:0]       r_remaining;
    logic [svs_pkg::DISP_W-1:0]      r_shown_h;
    logic [svs_pkg::DISP_W-1:0]      r_shown_m;
    logic [svs_pkg::DISP_W-1:0]      r_shown_s;

    logic [1:0]                      n_supply_state;
    logic                            n_started;
    logic [1:0]                      n_uv_code;
    logic [1:0]                      n_mark;
    logic                            n_valve;
    logic [svs_pkg::REM_W-1:0]       n_remaining;
    logic [svs_pkg::DISP_W-1:0]      n_shown_h;
    logic [svs_pkg::DISP_W-1:0]      n_shown_m;
    logic [svs_pkg::DISP_W-1:0]      n_shown_s;

    logic        r_req_type;
    logic [9:0]  r_adc_code;
    logic        r_comm_busy;

    logic [22:0]               r_prod1;
    logic [29:0]               r_prod2;
    logic [39:0]               r_part_hi;
    logic [39:0]               r_part_lo;
    logic                      r_sat;
    logic [svs_pkg::MV_W-1:0]  r_mv;
    logic [6:0]                r_hq;
    logic [11:0]               r_rem_h;
    logic [5:0]                r_mq;
    logic [5:0]                r_sec;

    logic [14:0] w_shifted;
    logic [52:0] w_sum;
    logic [28:0] w_hprod;
    logic [17:0] w_rem;
    logic [19:0] w_mprod;
    logic [11:0] w_sec;

    logic [21:0] w_mv_ext;
    logic [21:0] w_mv_p;
    logic        w_le_under, w_le_low, w_le_cut;
    logic        w_gtp_under, w_gtp_low, w_gtm_cut;
    logic [3:0]  w_event;
    logic        w_save;
    logic        w_reload;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_volt_under <= svs_pkg::RST_VOLT_UNDER;
            r_volt_low   <= svs_pkg::RST_VOLT_LOW;
            r_volt_cut   <= svs_pkg::RST_VOLT_CUT;
            r_volt_start <= svs_pkg::RST_VOLT_START;
            r_ref_mv     <= svs_pkg::RST_REF_MV;
            r_div_gain   <= svs_pkg::RST_DIV_GAIN;
            r_eight_bit  <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                svs_pkg::CFG_VOLT_UNDER: r_volt_under <= i_cfg_data;
                svs_pkg::CFG_VOLT_LOW:   r_volt_low   <= i_cfg_data;
                svs_pkg::CFG_VOLT_CUT:   r_volt_cut   <= i_cfg_data;
                svs_pkg::CFG_VOLT_START: r_volt_start <= i_cfg_data;
                svs_pkg::CFG_REF_MV:     r_ref_mv     <= i_cfg_data[12:0];
                svs_pkg::CFG_DIV_GAIN:   r_div_gain   <= i_cfg_data[14:0];
                svs_pkg::CFG_EIGHT_BIT:  r_eight_bit  <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    assign w_shifted = r_eight_bit ? 15'(r_prod1 >> 8) : 15'(r_prod1 >> 10);
    assign w_sum     = {r_part_hi, 13'd0} + {13'd0, r_part_lo};
    assign w_hprod   = 29'(r_remaining[17:4]) * 29'(svs_pkg::HOUR_RECIP);
    assign w_rem     = r_remaining - 18'(r_hq) * 18'(svs_pkg::SECS_PER_HOUR);
    assign w_mprod   = 20'(r_rem_h[11:2]) * 20'(svs_pkg::MIN_RECIP);
    assign w_sec     = r_rem_h - 12'(r_mq) * 12'(svs_pkg::SECS_PER_MIN);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_req_type  <= i_req_type;
            r_adc_code  <= i_adc_code;
            r_comm_busy <= i_comm_busy;
        end
        if (i_cmd.step1) begin
            r_prod1 <= 23'(r_adc_code) * 23'(r_ref_mv);
            r_hq    <= w_hprod[28:22];
        end
        if (i_cmd.step2) begin
            r_prod2 <= 30'(w_shifted) * 30'(r_div_gain);
            r_rem_h <= w_rem[11:0];
        end
        if (i_cmd.step3) begin
            r_part_hi <= 40'(r_prod2[27:15]) * 40'(svs_pkg::DIV100_RECIP);
            r_part_lo <= 40'(r_prod2[14:2]) * 40'(svs_pkg::DIV100_RECIP);
            r_sat     <= (r_prod2 >= svs_pkg::SAT_LIMIT);
            r_mq      <= w_mprod[19:14];
        end
        if (i_cmd.step4) begin
            r_mv  <= r_sat ? svs_pkg::MV_MAX : w_sum[51:31];
            r_sec <= w_sec[5:0];
        end
    end

    assign w_mv_ext    = {1'b0, r_mv};
    assign w_mv_p      = w_mv_ext + svs_pkg::HYST_MV;
    assign w_le_under  = w_mv_p <= {6'd0, r_volt_under};
    assign w_le_low    = w_mv_p <= {6'd0, r_volt_low};
    assign w_le_cut    = w_mv_p <= {6'd0, r_volt_cut};
    assign w_gtp_under = w_mv_ext > ({6'd0, r_volt_under} + svs_pkg::HYST_MV);
    assign w_gtp_low   = w_mv_ext > ({6'd0, r_volt_low} + svs_pkg::HYST_MV);
    assign w_gtm_cut   = w_mv_p > {6'd0, r_volt_cut};

    always_comb begin
        n_supply_state = r_supply_state;
        n_started      = r_started;
        n_uv_code      = r_uv_code;
        n_mark         = r_mark;
        n_valve        = r_valve;
        n_remaining    = r_remaining;
        n_shown_h      = r_shown_h;
        n_shown_m      = r_shown_m;
        n_shown_s      = r_shown_s;
        w_event        = svs_pkg::EV_NONE;
        w_save         = 1'b0;
        w_reload       = 1'b0;

        if (r_req_type == svs_pkg::REQ_TICK) begin
            if (r_uv_code == svs_pkg::UV_COUNTING && r_supply_state == svs_pkg::ST_UNDER) begin
                if (r_remaining != '0) begin
                    n_shown_h   = (r_hq > svs_pkg::HOURS_SHOWN_MAX) ? 6'h3f : r_hq[5:0];
                    n_shown_m   = r_mq;
                    n_shown_s   = r_sec;
                    n_remaining = r_remaining - 18'd1;
                end else begin
                    n_remaining = '0;
                    n_shown_h   = '0;
                    n_shown_m   = '0;
                    n_shown_s   = '0;
                    n_uv_code   = svs_pkg::UV_EXPIRED;
                    n_valve     = 1'b1;
                end
            end else begin
                n_remaining = '0;
                n_shown_h   = '0;
                n_shown_m   = '0;
                n_shown_s   = '0;
            end
        end else if (!r_started) begin
            if (r_mv >= 21'(r_volt_start)) begin
                n_started = 1'b1;
                w_reload  = 1'b1;
                w_event   = svs_pkg::EV_STARTUP;
                if (r_mv > 21'(r_volt_under)) begin
                    n_supply_state = svs_pkg::ST_NORMAL;
                end else if (r_mv > 21'(r_volt_low)) begin
                    n_supply_state = svs_pkg::ST_UNDER;
                end else if (r_mv >= 21'(r_volt_cut)) begin
                    n_supply_state = svs_pkg::ST_LOW;
                end else begin
                    n_supply_state = svs_pkg::ST_CUT;
                end
                if (n_supply_state != svs_pkg::ST_NORMAL) begin
                    n_valve   = 1'b1;
                    n_uv_code = svs_pkg::UV_LOW_CUT;
                end else begin
                    n_valve   = 1'b0;
                    n_uv_code = svs_pkg::UV_NONE;
                end
            end
        end else begin
            case (r_supply_state)
                svs_pkg::ST_NORMAL: begin
                    if (w_le_cut) begin
                        n_supply_state = svs_pkg::ST_CUT;
                        n_valve        = 1'b1;
                        n_uv_code      = svs_pkg::UV_LOW_CUT;
                        w_event        = svs_pkg::EV_NORMAL_CUT;
                        w_save         = 1'b1;
                    end else if (w_le_low) begin
                        n_supply_state = svs_pkg::ST_LOW;
                        n_valve        = 1'b1;
                        n_uv_code      = svs_pkg::UV_LOW_CUT;
                        w_event        = svs_pkg::EV_NORMAL_LOW;
                        w_save         = 1'b1;
                    end else if (w_le_under && !r_comm_busy) begin
                        n_supply_state = svs_pkg::ST_UNDER;
                        n_mark         = svs_pkg::MARK_FROM_NORMAL;
                        n_remaining    = svs_pkg::COUNTDOWN_LOAD;
                        n_uv_code      = svs_pkg::UV_COUNTING;
                        w_event        = svs_pkg::EV_NORMAL_UNDER;
                    end
                end
                svs_pkg::ST_UNDER: begin
                    if (w_gtp_under) begin
                        n_supply_state = svs_pkg::ST_NORMAL;
                        n_mark         = svs_pkg::MARK_CLEAR;
                        n_valve        = 1'b0;
                        n_remaining    = '0;
                        n_shown_h      = '0;
                        n_shown_m      = '0;
                        n_shown_s      = '0;
                        n_uv_code      = svs_pkg::UV_NONE;
                        w_event        = svs_pkg::EV_UNDER_NORMAL;
                    end else if (w_le_low || w_le_cut) begin
                        n_supply_state = w_le_low ? svs_pkg::ST_LOW : svs_pkg::ST_CUT;
                        n_valve        = 1'b1;
                        n_remaining    = '0;
                        n_shown_h      = '0;
                        n_shown_m      = '0;
                        n_shown_s      = '0;
                        n_uv_code      = svs_pkg::UV_LOW_CUT;
                        w_event        = w_le_low ? svs_pkg::EV_UNDER_LOW
                                                  : svs_pkg::EV_UNDER_CUT;
                        w_save         = 1'b1;
                    end
                end
                svs_pkg::ST_LOW: begin
                    if (w_gtp_under) begin
                        n_supply_state = svs_pkg::ST_NORMAL;
                        w_reload       = 1'b1;
                        n_mark         = svs_pkg::MARK_CLEAR;
                        n_valve        = 1'b0;
                        n_remaining    = '0;
                        n_shown_h      = '0;
                        n_shown_m      = '0;
                        n_shown_s      = '0;
                        n_uv_code      = svs_pkg::UV_NONE;
                        w_event        = svs_pkg::EV_LOW_NORMAL;
                    end else if (w_gtp_low) begin
                        n_supply_state = svs_pkg::ST_UNDER;
                        n_mark         = svs_pkg::MARK_FROM_LOW;
                        w_reload       = 1'b1;
                        n_uv_code      = svs_pkg::UV_LOW_CUT;
                        w_event        = svs_pkg::EV_LOW_UNDER;
                    end else if (w_le_cut) begin
                        n_supply_state = svs_pkg::ST_CUT;
                        n_uv_code      = svs_pkg::UV_LOW_CUT;
                        w_event        = svs_pkg::EV_LOW_CUT;
                    end
                end
                default: begin
                    if (w_gtp_under) begin
                        n_supply_state = svs_pkg::ST_NORMAL;
                        w_reload       = 1'b1;
                        n_remaining    = '0;
                        n_shown_h      = '0;
                        n_shown_m      = '0;
                        n_shown_s      = '0;
                        n_mark         = svs_pkg::MARK_CLEAR;
                        n_valve        = 1'b0;
                        n_uv_code      = svs_pkg::UV_NONE;
                        w_event        = svs_pkg::EV_CUT_NORMAL;
                    end else if (w_gtp_low) begin
                        n_supply_state = svs_pkg::ST_UNDER;
                        n_mark         = svs_pkg::MARK_FROM_LOW;
                        w_reload       = 1'b1;
                        n_uv_code      = svs_pkg::UV_LOW_CUT;
                        w_event        = svs_pkg::EV_CUT_UNDER;
                    end else if (w_gtm_cut) begin
                        n_supply_state = svs_pkg::ST_LOW;
                        n_uv_code      = svs_pkg::UV_LOW_CUT;
                        w_event        = svs_pkg::EV_CUT_LOW;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_supply_state <= svs_pkg::ST_CUT;
            r_started      <= 1'b0;
            r_uv_code      <= svs_pkg::UV_NONE;
            r_mark         <= svs_pkg::MARK_CLEAR;
            r_valve        <= 1'b0;
            r_remaining    <= '0;
            r_shown_h      <= '0;
            r_shown_m      <= '0;
            r_shown_s      <= '0;
        end else if (i_cmd.commit) begin
            r_supply_state <= n_supply_state;
            r_started      <= n_started;
            r_uv_code      <= n_uv_code;
            r_mark         <= n_mark;
            r_valve        <= n_valve;
            r_remaining    <= n_remaining;
            r_shown_h      <= n_shown_h;
            r_shown_m      <= n_shown_m;
            r_shown_s      <= n_shown_s;
        end
    end

    always_comb begin
        o_result.power_state          = n_supply_state;
        o_result.measured_mv          = (r_req_type == svs_pkg::REQ_TICK) ? '0 : r_mv;
        o_result.transition_event     = w_event;
        o_result.undervolt_flag       = n_uv_code;
        o_result.normal_to_under_mark = n_mark;
        o_result.valve_hold           = n_valve;
        o_result.save_request         = w_save;
        o_result.reload_request       = w_reload;
        o_result.hours_left           = n_shown_h;
        o_result.minutes_left         = n_shown_m;
        o_result.seconds_left         = n_shown_s;
    end

endmodule

// ===== rtl/core/supply_voltage_supervisor.sv =====
// Top level of the supply voltage supervisor: sequencer, datapath and result register.
//
// The input channel carries one item per handshake: either an ADC voltage
// sample or a one-second countdown tick. Every item yields exactly one result
// item on the output channel, in order. Thresholds, ADC reference, divider gain
// and shift select are written through a plain write port; the user must write
// them only while the block idles, and the block itself does not enforce it.
// A sample is scaled over four steps (product, gain, split reciprocal division
// by 100, saturation), and the supervisor state is updated in the commit step;
// ticks use the same steps for the hours and minutes split. An item is loaded,
// passes the four steps and is committed; the sequencer handles one item at a
// time. The result register frees the input side: a new item is accepted while
// the previous result still waits, and it is held at its commit step until the
// receiver takes that result. After the synchronous reset the supply state is
// cut, the supervisor is not started, every configuration register holds its
// default and no result is pending.
module supply_voltage_supervisor (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic                                i_req_type,
    input  logic [9:0]                          i_adc_code,
    input  logic                                i_comm_busy,
    input  logic                                i_cfg_we,
    input  logic [svs_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [svs_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic [1:0]                          o_power_state,
    output logic [svs_pkg::MV_W-1:0]            o_measured_mv,
    output logic [3:0]                          o_transition_event,
    output logic [1:0]                          o_undervolt_flag,
    output logic [1:0]                          o_normal_to_under_mark,
    output logic                                o_valve_hold,
    output logic                                o_save_request,
    output logic                                o_reload_request,
    output logic [svs_pkg::DISP_W-1:0]          o_hours_left,
    output logic [svs_pkg::DISP_W-1:0]          o_minutes_left,
    output logic [svs_pkg::DISP_W-1:0]          o_seconds_left
);

    svs_pkg::t_cmd    w_cmd;
    svs_pkg::t_status w_status;
    svs_pkg::t_result w_result;
    svs_pkg::t_result r_out;
    logic             r_out_valid;
    logic             w_idle;

    assign o_in_ready         = w_idle;
    assign w_status.in_accept = i_in_valid && w_idle;
    assign w_status.out_free  = !r_out_valid || i_out_ready;

    svs_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_status (w_status),
        .o_idle   (w_idle),
        .o_cmd    (w_cmd)
    );

    svs_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_req_type  (i_req_type),
        .i_adc_code  (i_adc_code),
        .i_comm_busy (i_comm_busy),
        .o_result    (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_cmd.commit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_cmd.commit) begin
            r_out <= w_result;
        end
    end

    assign o_out_valid            = r_out_valid;
    assign o_power_state          = r_out.power_state;
    assign o_measured_mv          = r_out.measured_mv;
    assign o_transition_event     = r_out.transition_event;
    assign o_undervolt_flag       = r_out.undervolt_flag;
    assign o_normal_to_under_mark = r_out.normal_to_under_mark;
    assign o_valve_hold           = r_out.valve_hold;
    assign o_save_request         = r_out.save_request;
    assign o_reload_request       = r_out.reload_request;
    assign o_hours_left           = r_out.hours_left;
    assign o_minutes_left         = r_out.minutes_left;
    assign o_seconds_left         = r_out.seconds_left;

    a_commit_needs_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.commit |-> (!r_out_valid || i_out_ready))
        else $error("Result committed while the output register was occupied.");

    a_accept_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_status.in_accept |=> !o_in_ready)
        else $error("Input stayed ready after an item was accepted.");

    a_startup_reloads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_transition_event == svs_pkg::EV_STARTUP) |-> o_reload_request)
        else $error("Start-up classification without a reload request.");

    a_save_reload_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_save_request && o_reload_request))
        else $error("Save and reload requested by the same item.");

endmodule
